### design/bdt_pkg.sv
package bdt_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT  = 2'd1;

  // Field widths fixed by the interface
  localparam int CFG_DATA_BITS = 13;
  localparam int ROW_BITS      = 11;
  localparam int COLUMN_BITS   = 12;

  // Lower limit on the configured column length
  localparam int MIN_LENGTH = 5;

  // Sums are kept in sixteenths and rounded half up
  localparam int FRAC_BITS  = 4;
  localparam int ROUND_BIAS = 8;

  // Kernel chosen for one result
  typedef enum logic [2:0] {
    KIND_FIRST,
    KIND_MID,
    KIND_PENULT,
    KIND_LAST_ODD,
    KIND_LAST_EVEN
  } kind_t;

  // Control side of an item between the sequencer and the output stage
  typedef struct packed {
    kind_t                  kind;
    logic [ROW_BITS-1:0]    row;
    logic [COLUMN_BITS-1:0] column;
    logic                   column_done;
    logic                   frame_done;
  } item_ctrl_t;

  // Configuration write transaction
  typedef struct packed {
    logic                      valid;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_write_t;

endpackage

### design/bdt_sequencer.sv
module bdt_sequencer #(
  parameter int MAX_COLUMN  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bdt_pkg::cfg_write_t        cfg,
  input  logic                       accept,
  input  logic [SAMPLE_BITS-1:0]     sample,
  input  logic                       advance,
  output logic                       item_valid,
  output bdt_pkg::item_ctrl_t        item_ctrl,
  output logic [SAMPLE_BITS-1:0]     item_taps [5]
);

  // The 13-bit register caps the usable length and count
  localparam int REG_MAX  = (1 << bdt_pkg::CFG_DATA_BITS) - 1;
  localparam int LEN_MAX  = (MAX_COLUMN < REG_MAX) ? MAX_COLUMN : REG_MAX;
  localparam int POS_BITS = $clog2(LEN_MAX);
  localparam int CB       = bdt_pkg::CFG_DATA_BITS;

  // Clamped configuration, held as derived compare values
  logic [POS_BITS-1:0] len_last;
  logic [POS_BITS-1:0] len_m2;
  logic                len_odd;
  logic [CB-1:0]       cnt_last;

  logic [CB-1:0] len_clamped;
  logic [CB-1:0] cnt_clamped;

  // A write to one of the two registers restarts the frame
  logic          cfg_hit;

  // Column state
  logic [POS_BITS-1:0]              position;
  logic [bdt_pkg::ROW_BITS-1:0]     row;
  logic [bdt_pkg::COLUMN_BITS-1:0]  column;
  logic [SAMPLE_BITS-1:0]           window [4];

  logic          is_last;
  logic          frame_end;
  logic          emit;
  bdt_pkg::kind_t kind;

  assign cfg_hit = cfg.valid && (cfg.index == bdt_pkg::REG_COLUMN_LENGTH ||
                                 cfg.index == bdt_pkg::REG_COLUMN_COUNT);

  // Clamp a register write into range
  always_comb begin
    if (cfg.data < CB'(bdt_pkg::MIN_LENGTH)) begin
      len_clamped = CB'(bdt_pkg::MIN_LENGTH);
    end else if (cfg.data > CB'(LEN_MAX)) begin
      len_clamped = CB'(LEN_MAX);
    end else begin
      len_clamped = cfg.data;
    end
    if (cfg.data == '0) begin
      cnt_clamped = CB'(1);
    end else if (cfg.data > CB'(LEN_MAX)) begin
      cnt_clamped = CB'(LEN_MAX);
    end else begin
      cnt_clamped = cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_last <= POS_BITS'(bdt_pkg::MIN_LENGTH - 1);
      len_m2   <= POS_BITS'(bdt_pkg::MIN_LENGTH - 2);
      len_odd  <= 1'b1;
      cnt_last <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        bdt_pkg::REG_COLUMN_LENGTH: begin
          len_last <= POS_BITS'(len_clamped - CB'(1));
          len_m2   <= POS_BITS'(len_clamped - CB'(2));
          len_odd  <= len_clamped[0];
        end
        bdt_pkg::REG_COLUMN_COUNT: begin
          cnt_last <= cnt_clamped - CB'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Pick the kernel for this sample position
  always_comb begin
    is_last   = (position >= len_last);
    frame_end = ({1'b0, column} >= cnt_last);
    emit      = 1'b0;
    kind      = bdt_pkg::KIND_MID;
    if (is_last) begin
      emit = 1'b1;
      kind = len_odd ? bdt_pkg::KIND_LAST_ODD : bdt_pkg::KIND_LAST_EVEN;
    end else if (position == POS_BITS'(2)) begin
      emit = 1'b1;
      kind = bdt_pkg::KIND_FIRST;
    end else if (!position[0] && position >= POS_BITS'(4)) begin
      emit = 1'b1;
      kind = bdt_pkg::KIND_MID;
    end else if (len_odd && position == len_m2) begin
      emit = 1'b1;
      kind = bdt_pkg::KIND_PENULT;
    end
  end

  // Position, row and column counters; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      position <= '0;
      row      <= '0;
      column   <= '0;
    end else if (accept) begin
      if (is_last) begin
        position <= '0;
        row      <= '0;
        column   <= frame_end ? '0 : column + 1'b1;
      end else begin
        position <= position + 1'b1;
        if (emit) begin
          row <= row + 1'b1;
        end
      end
    end
  end

  // Last four samples
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        window[i] <= '0;
      end
    end else if (accept) begin
      window[0] <= sample;
      for (int i = 1; i < 4; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

  // Input register of the filter stage
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept && emit) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      item_ctrl.kind        <= kind;
      item_ctrl.row         <= row;
      item_ctrl.column      <= column;
      item_ctrl.column_done <= is_last;
      item_ctrl.frame_done  <= is_last && frame_end;
      item_taps[0]          <= sample;
      for (int i = 1; i < 5; i++) begin
        item_taps[i] <= window[i-1];
      end
    end
  end

  // The first row of a column is always row zero
  a_first_row_zero: assert property (@(posedge clk) disable iff (rst)
    accept && emit && kind == bdt_pkg::KIND_FIRST |-> row == '0)
    else $error("first kernel issued at non-zero row");

  // A column end always restarts the position
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && is_last && !cfg.valid |=> position == '0)
    else $error("position not cleared after column end");

endmodule

### design/bdt_filter.sv
module bdt_filter #(
  parameter int SAMPLE_BITS = 16
) (
  input  bdt_pkg::kind_t          kind,
  input  logic [SAMPLE_BITS-1:0]  taps [5],
  output logic [SAMPLE_BITS-1:0]  filtered
);

  localparam int SUM_BITS = SAMPLE_BITS + bdt_pkg::FRAC_BITS;

  logic [SUM_BITS-1:0] e [5];
  logic [SUM_BITS-1:0] sum;
  logic [SUM_BITS-1:0] rounded;

  // Widen the taps so sums in sixteenths cannot overflow
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      e[i] = SUM_BITS'(taps[i]);
    end
  end

  // Constant weights built from shifts and adds
  always_comb begin
    case (kind)
      bdt_pkg::KIND_FIRST:
        sum = (e[2] << 3) + (e[2] << 1) + e[2] + (e[1] << 2) + e[0];
      bdt_pkg::KIND_MID:
        sum = e[0] + (e[1] << 2) + (e[2] << 2) + (e[2] << 1) + (e[3] << 2) + e[4];
      bdt_pkg::KIND_PENULT:
        sum = (e[0] << 2) + e[0] + (e[1] << 2) + (e[1] << 1) + (e[2] << 2) + e[3];
      bdt_pkg::KIND_LAST_ODD:
        sum = (e[0] << 3) + (e[0] << 1) + e[0] + (e[1] << 2) + e[2];
      bdt_pkg::KIND_LAST_EVEN:
        sum = (e[1] << 3) + (e[1] << 1) + e[1] + (e[2] << 2) + e[3];
      default:
        sum = '0;
    endcase
  end

  // Round half up, drop the fraction
  always_comb begin
    rounded  = (sum + SUM_BITS'(bdt_pkg::ROUND_BIAS)) >> bdt_pkg::FRAC_BITS;
    filtered = rounded[SAMPLE_BITS-1:0];
  end

endmodule

### design/binomial_decimate_by_two.sv
// Channel   Direction  Transaction              Payload
// s_*       in         one sample               tdata: sample
// m_*       out        one decimated result     tdata: filtered, out_row, out_column;
//                                               tlast: column_done; tuser: frame_done
// cfg_*     in         one register write       cfg_index, cfg_data
//
// One sample is accepted every cycle while s_tready is high; a result passes the
// filter input register, then the output register, after the sample that completes it.
// Each column of L samples gives ceil(L/2) results; other samples give none.
// rst is synchronous: column length 5, column count 1, counters and window clear.
// When m_tready is low with m_tvalid high, the output register holds and the filter
// input register keeps its item; s_tready drops only while both are full.
module binomial_decimate_by_two #(
  parameter int MAX_COLUMN  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_BITS+bdt_pkg::ROW_BITS+bdt_pkg::COLUMN_BITS+7)/8)*8-1:0] m_tdata,
                                                        // filtered, out_row, out_column
  output logic                                m_tlast,  // column_done
  output logic                                m_tuser,  // frame_done
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bdt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bdt_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int TDATA_BITS =
    ((SAMPLE_BITS + bdt_pkg::ROW_BITS + bdt_pkg::COLUMN_BITS + 7) / 8) * 8;

  bdt_pkg::cfg_write_t cfg;
  bdt_pkg::item_ctrl_t item_ctrl;
  bdt_pkg::item_ctrl_t out_ctrl;

  logic                   accept;
  logic                   advance;
  logic                   out_free;
  logic                   item_valid;
  logic [SAMPLE_BITS-1:0] item_taps [5];
  logic [SAMPLE_BITS-1:0] filtered;
  logic [SAMPLE_BITS-1:0] out_filtered;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = item_valid && out_free;
  assign s_tready = !item_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  bdt_sequencer #(
    .MAX_COLUMN  (MAX_COLUMN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sequencer (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .sample     (s_tdata[SAMPLE_BITS-1:0]),
    .advance    (advance),
    .item_valid (item_valid),
    .item_ctrl  (item_ctrl),
    .item_taps  (item_taps)
  );

  bdt_filter #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_filter (
    .kind     (item_ctrl.kind),
    .taps     (item_taps),
    .filtered (filtered)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_filtered <= filtered;
      out_ctrl     <= item_ctrl;
    end
  end

  assign m_tdata = TDATA_BITS'({out_ctrl.column, out_ctrl.row, out_filtered});
  assign m_tlast = out_ctrl.column_done;
  assign m_tuser = out_ctrl.frame_done;

  // A frame end is always a column end
  a_frame_is_column_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame_done without column_done");

  // With both stages empty s_tready is always high
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !item_valid && !m_tvalid |-> s_tready)
    else $error("s_tready low with empty pipeline");

  // A blocked filter stage keeps its item
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !out_free |=> item_valid && $stable(item_ctrl))
    else $error("filter stage item lost under stall");

endmodule

### test/tb_binomial_decimate_by_two.sv
`timescale 1ns / 100ps

module tb_binomial_decimate_by_two;

  localparam int MAX_COLUMN     = 4096;
  localparam int SAMPLE_BITS    = 16;
  localparam int ROW_BITS       = bdt_pkg::ROW_BITS;
  localparam int COLUMN_BITS    = bdt_pkg::COLUMN_BITS;
  localparam int CFG_INDEX_BITS = bdt_pkg::CFG_INDEX_BITS;
  localparam int CFG_DATA_BITS  = bdt_pkg::CFG_DATA_BITS;
  localparam int MIN_LENGTH     = bdt_pkg::MIN_LENGTH;
  localparam int S_BITS      = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int M_BITS      = ((SAMPLE_BITS + ROW_BITS + COLUMN_BITS + 7) / 8) * 8;
  localparam int ROW_LSB     = SAMPLE_BITS;
  localparam int COL_LSB     = SAMPLE_BITS + ROW_BITS;
  localparam int CFG_MAX     = (1 << CFG_DATA_BITS) - 1;
  // unmapped register indexes: writes there must change nothing
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 100000;
  localparam int LIMIT_NS      = 4000000;
  localparam int REPORT_LIMIT  = 10;
  localparam int LONG_RUN      = 120;

  // one decimated output pixel
  typedef struct {
    logic [SAMPLE_BITS-1:0] filtered;
    logic [ROW_BITS-1:0]    row;
    logic [COLUMN_BITS-1:0] column;
    logic                   column_done;
    logic                   frame_done;
  } pixel_t;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [S_BITS-1:0]         s_tdata;  // sample
  logic                      m_tvalid;
  logic                      m_tready;
  logic [M_BITS-1:0]         m_tdata;  // filtered, out_row, out_column
  logic                      m_tlast;  // column_done
  logic                      m_tuser;  // frame_done
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // mirror of the block's registers and column state
  logic [CFG_DATA_BITS-1:0]  cfg_length;
  logic [CFG_DATA_BITS-1:0]  cfg_count;
  logic [SAMPLE_BITS-1:0]    win [4];
  logic [19:0]               pos;
  logic [ROW_BITS-1:0]       next_row;
  logic [COLUMN_BITS-1:0]    cur_col;

  pixel_t pending_pixels [$];
  int     failures;
  int     samples_sent;
  int     tx_idle_pct;
  int     rx_idle_pct;

  binomial_decimate_by_two #(
    .MAX_COLUMN  (MAX_COLUMN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  function automatic int clamp_setting(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic note_failure(input string msg);
    if (failures < REPORT_LIMIT) $display("ERROR: %s", msg);
    failures++;
  endtask

  // Advance the mirror by one sample and queue the pixel it completes, if any
  task automatic reduce_sample(input logic [SAMPLE_BITS-1:0] x);
    int          len;
    int          cnt;
    bit          odd;
    bit          is_last;
    bit          emit;
    int unsigned sum;
    pixel_t      px;
    len     = clamp_setting(int'(cfg_length), MIN_LENGTH, MAX_COLUMN);
    cnt     = clamp_setting(int'(cfg_count), 1, MAX_COLUMN);
    odd     = len[0];
    is_last = (pos >= len - 1);
    emit    = 1'b1;
    sum     = 0;
    if (is_last) begin
      // bottom edge; for even lengths the newest sample is dropped
      if (odd) sum = 11 * x + 4 * win[0] + win[1];
      else sum = 11 * win[0] + 4 * win[1] + win[2];
    end else if (pos == 2) begin
      // top edge
      sum = 11 * win[1] + 4 * win[0] + x;
    end else if (!pos[0] && pos >= 4 && pos <= len - 2) begin
      sum = x + 4 * win[0] + 6 * win[1] + 4 * win[2] + win[3];
    end else if (odd && pos == len - 2) begin
      // second from bottom, odd lengths only
      sum = 5 * x + 6 * win[0] + 4 * win[1] + win[2];
    end else begin
      emit = 1'b0;
    end

    if (emit) begin
      px.filtered    = SAMPLE_BITS'((sum + bdt_pkg::ROUND_BIAS) >> bdt_pkg::FRAC_BITS);
      px.row         = next_row;
      px.column      = cur_col;
      px.column_done = is_last;
      px.frame_done  = is_last && (cur_col >= cnt - 1);
      pending_pixels.push_back(px);
      next_row = next_row + 1'b1;
    end

    win[3] = win[2];
    win[2] = win[1];
    win[1] = win[0];
    win[0] = x;

    if (is_last) begin
      pos      = '0;
      next_row = '0;
      cur_col  = (cur_col >= cnt - 1) ? '0 : cur_col + 1'b1;
    end else begin
      pos = pos + 1'b1;
    end
  endtask

  // Send one sample; entered and left at a falling edge, tvalid left high
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = S_BITS'(value);
    do @(posedge clk); while (!s_tready);
    reduce_sample(value);
    samples_sent++;
    @(negedge clk);
  endtask

  // One register write transaction; only issued while the block is idle
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bdt_pkg::REG_COLUMN_LENGTH || idx == bdt_pkg::REG_COLUMN_COUNT) begin
      if (idx == bdt_pkg::REG_COLUMN_LENGTH) cfg_length = value;
      else cfg_count = value;
      pos      = '0;
      next_row = '0;
      cur_col  = '0;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold the sender off until every queued pixel has come out
  task automatic settle();
    s_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return SAMPLE_BITS'($urandom_range(15));
      3: return {SAMPLE_BITS{1'b1}} - SAMPLE_BITS'($urandom_range(15));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Check each result transaction against the oldest queued pixel
  always @(posedge clk) begin : check_results
    pixel_t want;
    pixel_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.filtered    = m_tdata[SAMPLE_BITS-1:0];
      got.row         = m_tdata[ROW_LSB +: ROW_BITS];
      got.column      = m_tdata[COL_LSB +: COLUMN_BITS];
      got.column_done = m_tlast;
      got.frame_done  = m_tuser;
      if (pending_pixels.size() == 0) begin
        note_failure($sformatf("unexpected result: filtered %0d row %0d column %0d",
                               got.filtered, got.row, got.column));
      end else begin
        want = pending_pixels.pop_front();
        if (got.filtered !== want.filtered || got.row !== want.row ||
            got.column !== want.column || got.column_done !== want.column_done ||
            got.frame_done !== want.frame_done) begin
          note_failure($sformatf(
            "expected filtered %0d row %0d col %0d last %0b frame %0b, got %0d %0d %0d %0b %0b",
            want.filtered, want.row, want.column, want.column_done, want.frame_done,
            got.filtered, got.row, got.column, got.column_done, got.frame_done));
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Reset values: length 5, one column per frame, one full-scale column then one of zeros
  task automatic test_default_frame();
    repeat (5) send_sample('1);
    repeat (5) send_sample('0);
    settle();
  endtask

  // Even length: final sample is ignored; top pixel hits an exact half
  task automatic test_even_length();
    write_register(bdt_pkg::REG_COLUMN_LENGTH, 6);
    write_register(bdt_pkg::REG_COLUMN_COUNT, 2);
    send_sample(16'd0);
    send_sample(16'd2);
    send_sample(16'd0);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h1234);
    settle();
  endtask

  // Out-of-range settings clamp; unmapped indexes are ignored, even mid-column
  task automatic test_clamped_settings();
    write_register(bdt_pkg::REG_COLUMN_LENGTH, 0);
    write_register(bdt_pkg::REG_COLUMN_COUNT, 0);
    write_register(REG_SPARE_A, CFG_DATA_BITS'(CFG_MAX));
    write_register(REG_SPARE_B, CFG_DATA_BITS'(CFG_MAX));
    send_sample(16'hAAAA);
    send_sample(16'h5555);
    settle();
    write_register(REG_SPARE_A, CFG_DATA_BITS'(CFG_MAX));
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h8000);
    settle();
  endtask

  // Random settings and whole columns (whole frames for small counts), with broken columns and pauses mixed in
  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int budget);
    int start;
    int len_eff;
    int cnt_eff;
    int columns;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start       = samples_sent;
    while (samples_sent - start < budget) begin
      settle();
      case ($urandom_range(9))
        0: write_register(bdt_pkg::REG_COLUMN_LENGTH,
                          CFG_DATA_BITS'($urandom_range(0, MIN_LENGTH - 1)));
        1: write_register(bdt_pkg::REG_COLUMN_LENGTH,
                          CFG_DATA_BITS'($urandom_range(21, 80)));
        default: write_register(bdt_pkg::REG_COLUMN_LENGTH,
                                CFG_DATA_BITS'($urandom_range(MIN_LENGTH, 20)));
      endcase
      case ($urandom_range(7))
        0: write_register(bdt_pkg::REG_COLUMN_COUNT, 0);
        1: write_register(bdt_pkg::REG_COLUMN_COUNT,
                          CFG_DATA_BITS'($urandom_range(MAX_COLUMN, CFG_MAX)));
        2: ; // keep the current count
        default: write_register(bdt_pkg::REG_COLUMN_COUNT,
                                CFG_DATA_BITS'($urandom_range(1, 4)));
      endcase
      if ($urandom_range(5) == 0)
        write_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                       CFG_DATA_BITS'($urandom));
      len_eff = clamp_setting(int'(cfg_length), MIN_LENGTH, MAX_COLUMN);
      cnt_eff = clamp_setting(int'(cfg_count), 1, MAX_COLUMN);
      columns = (cnt_eff <= 4) ? cnt_eff * $urandom_range(1, 2) : $urandom_range(2, 6);
      repeat (columns) begin
        repeat (len_eff) send_sample(random_sample());
        if ($urandom_range(9) == 0) settle();
      end
      // column cut short by the next register write
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, len_eff - 1)) send_sample(random_sample());
    end
    settle();
  endtask

  // Largest settings: the opening rows of a maximum-length column
  task automatic test_longest_column();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_register(bdt_pkg::REG_COLUMN_LENGTH, CFG_DATA_BITS'(CFG_MAX));
    write_register(bdt_pkg::REG_COLUMN_COUNT, CFG_DATA_BITS'(CFG_MAX));
    repeat (LONG_RUN) send_sample(random_sample());
    settle();
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    failures    = 0;
    samples_sent = 0;
    tx_idle_pct = 8;
    rx_idle_pct = 73;
    cfg_length  = CFG_DATA_BITS'(MIN_LENGTH);
    cfg_count   = CFG_DATA_BITS'(1);
    for (int i = 0; i < 4; i++) win[i] = '0;
    pos         = '0;
    next_row    = '0;
    cur_col     = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_default_frame();
    test_even_length();
    test_clamped_settings();
    test_random_traffic(8, 73, 200);
    test_random_traffic(73, 8, 200);
    test_random_traffic(0, 0, 210);
    test_longest_column();

    // final drain, bounded
    s_tvalid = 1'b0;
    repeat (DRAIN_LIMIT) begin
      if (pending_pixels.size() == 0) break;
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_pixels.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_pixels.size()));

    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
